>>> sv/ead_pkg.sv
// Package for the exponential atmosphere density block: types, band table and step factors.
`default_nettype none

package ead_pkg;

  // Sizes
  localparam int TABLE_LEN     = 28;
  localparam int FRAC_BITS     = 24;
  localparam int NUM_BANDS_DEF = 28;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Field and datapath widths
  localparam int ALT_W  = 32;
  localparam int DIST_W = 31;
  localparam int IDX_W  = 5;
  localparam int MANT_W = 24;
  localparam int EXP_W  = 9;
  localparam int K_W    = 27;
  localparam int SEXP_W = 6;
  localparam int ACC_W  = 31;
  localparam int PROD_W = DIST_W + K_W;
  localparam int N_W    = PROD_W - 44;
  localparam int DEC_W  = 15;

  // log2(e) in Q36
  localparam logic [63:0] LOG2E_Q36 = 64'h0000_0017_1547_652C;

  // Reference bands: base height in km, density digits and power of ten, scale height in m
  localparam int unsigned BASE_KM [TABLE_LEN] = '{
    0, 25, 30, 40, 50, 60, 70, 80, 90, 100, 110, 120, 130, 140,
    150, 180, 200, 250, 300, 350, 400, 450, 500, 600, 700, 800, 900, 1000};
  localparam int unsigned RHO_DIGITS [TABLE_LEN] = '{
    1225, 3899, 1774, 3972, 1057, 3206, 8770, 1905, 3396, 5297, 9661, 2438,
    8484, 3845, 2070, 5464, 2789, 7248, 2418, 9518, 3725, 1585, 6967, 1454,
    3614, 1170, 5245, 3019};
  localparam int unsigned RHO_POW10 [TABLE_LEN] = '{
    3, 5, 5, 6, 6, 7, 8, 8, 9, 10, 11, 11, 12, 12, 12, 13, 13, 14, 14, 15,
    15, 15, 16, 16, 17, 17, 18, 18};
  localparam int unsigned SCALE_MILLI [TABLE_LEN] = '{
    7249, 6349, 6682, 7554, 8382, 7714, 6549, 5799, 5382, 5877, 7263, 9473,
    12636, 16149, 22523, 29740, 37105, 45546, 53628, 53298, 58515, 60828,
    63822, 71835, 88667, 124640, 181050, 268000};

  // Band base heights in 5 km steps
  localparam int unsigned BASE_STEP [TABLE_LEN] = '{
    0, 5, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26, 28,
    30, 36, 40, 50, 60, 70, 80, 90, 100, 120, 140, 160, 180, 200};

  // Rate in Q28 per km: log2(e) over the scale height, rounded to nearest
  localparam logic [63:0] RATE_NUM = LOG2E_Q36 * 64'd1000;
  localparam logic [63:0] RATE_K [TABLE_LEN] = '{
    (RATE_NUM + 64'(SCALE_MILLI[0])  * 64'd128) / (64'(SCALE_MILLI[0])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[1])  * 64'd128) / (64'(SCALE_MILLI[1])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[2])  * 64'd128) / (64'(SCALE_MILLI[2])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[3])  * 64'd128) / (64'(SCALE_MILLI[3])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[4])  * 64'd128) / (64'(SCALE_MILLI[4])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[5])  * 64'd128) / (64'(SCALE_MILLI[5])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[6])  * 64'd128) / (64'(SCALE_MILLI[6])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[7])  * 64'd128) / (64'(SCALE_MILLI[7])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[8])  * 64'd128) / (64'(SCALE_MILLI[8])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[9])  * 64'd128) / (64'(SCALE_MILLI[9])  * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[10]) * 64'd128) / (64'(SCALE_MILLI[10]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[11]) * 64'd128) / (64'(SCALE_MILLI[11]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[12]) * 64'd128) / (64'(SCALE_MILLI[12]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[13]) * 64'd128) / (64'(SCALE_MILLI[13]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[14]) * 64'd128) / (64'(SCALE_MILLI[14]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[15]) * 64'd128) / (64'(SCALE_MILLI[15]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[16]) * 64'd128) / (64'(SCALE_MILLI[16]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[17]) * 64'd128) / (64'(SCALE_MILLI[17]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[18]) * 64'd128) / (64'(SCALE_MILLI[18]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[19]) * 64'd128) / (64'(SCALE_MILLI[19]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[20]) * 64'd128) / (64'(SCALE_MILLI[20]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[21]) * 64'd128) / (64'(SCALE_MILLI[21]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[22]) * 64'd128) / (64'(SCALE_MILLI[22]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[23]) * 64'd128) / (64'(SCALE_MILLI[23]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[24]) * 64'd128) / (64'(SCALE_MILLI[24]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[25]) * 64'd128) / (64'(SCALE_MILLI[25]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[26]) * 64'd128) / (64'(SCALE_MILLI[26]) * 64'd256),
    (RATE_NUM + 64'(SCALE_MILLI[27]) * 64'd128) / (64'(SCALE_MILLI[27]) * 64'd256)};

  typedef logic [TABLE_LEN-1:0][63:0]       rom_t;
  typedef logic [TABLE_LEN-1:0][ALT_W-1:0]  base_tab_t;
  typedef logic [FRAC_BITS:0][ACC_W-1:0]    pow_tab_t;

  // One classified altitude on its way from the front end to the evaluator
  typedef struct packed {
    logic              below;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] alt;
  } item_t;

  // Floor square root, one result bit per step
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    int          j;
    x     = x_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (j = 0; j < 32; j++) begin
      if (bit_v != 64'd0) begin
        if (x >= res + bit_v) begin
          x   = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Band word: [22:0] mantissa fraction, [28:23] shift, [36:29] base/5 km, [63:37] rate
  function automatic logic [63:0] band_entry(input int idx);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] k;
    int          s;
    int          j;
    num = 64'(RHO_DIGITS[idx]);
    den = 64'd1;
    s   = 0;
    for (j = 0; j < int'(RHO_POW10[idx]); j++) den = den * 64'd10;
    for (j = 0; j < 64; j++) begin
      if (num < den) begin
        num = num << 1;
        s   = s + 1;
      end
    end
    for (j = 0; j < 64; j++) begin
      if (num >= (den << 1)) begin
        den = den << 1;
        s   = s - 1;
      end
    end
    m = 64'd1;
    r = num - den;
    for (j = 0; j < 23; j++) begin
      r = r << 1;
      m = m << 1;
      if (r >= den) begin
        r = r - den;
        m = m | 64'd1;
      end
    end
    r = r << 1;
    if (r >= den) m = m + 64'd1;
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      s = s - 1;
    end
    k = RATE_K[idx];
    return (m & 64'h7F_FFFF) | (64'(s & 63) << 23) | (64'(BASE_STEP[idx]) << 29)
         | ((k & 64'h7FF_FFFF) << 37);
  endfunction

  function automatic rom_t build_band_rom();
    rom_t rom;
    int   i;
    for (i = 0; i < TABLE_LEN; i++) rom[i] = band_entry(i);
    return rom;
  endfunction

  localparam rom_t BAND_ROM = build_band_rom();

  // Band base heights in Q16 km
  function automatic base_tab_t build_base_tab();
    base_tab_t tab;
    int        i;
    for (i = 0; i < TABLE_LEN; i++) begin
      tab[i] = ALT_W'((64'(BAND_ROM[i][36:29]) * 64'd5) << 16);
    end
    return tab;
  endfunction

  localparam base_tab_t BASE_TAB = build_base_tab();

  // 2^(-2^-i) in Q31 by repeated square roots from one half
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] cur;
    int          i;
    cur    = 64'd1 << 30;
    tab[0] = ACC_W'(cur);
    for (i = 1; i <= FRAC_BITS; i++) begin
      cur    = isqrt64(cur << 31);
      tab[i] = ACC_W'(cur);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

>>> sv/ead_queue.sv
// Small register FIFO between the front end and the evaluator.
`default_nettype none

module ead_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_en, rd_en;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and count update, pointers wrap at DEPTH
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue count missed a write");

endmodule

`default_nettype wire

>>> sv/ead_front.sv
// Front end: takes altitudes, flags negative ones and picks the band.
`default_nettype none

module ead_front import ead_pkg::*; #(
  parameter int NUM_BANDS = NUM_BANDS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ALT_W-1:0] in_altitude,
  input  wire logic                    q_full,
  output logic                         q_push,
  output item_t                        q_item
);

  localparam int NB_CAP  = (NUM_BANDS < TABLE_LEN) ? NUM_BANDS : TABLE_LEN;
  localparam int NB_USED = (NB_CAP < 1) ? 1 : NB_CAP;

  logic                    hold_valid_r, hold_valid_nxt;
  logic signed [ALT_W-1:0] alt_r;
  logic                    accept;
  logic                    below;
  logic [IDX_W-1:0]        idx;

  // Holding register: stalls only while the queue is full
  assign in_stall = hold_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_valid_r && !q_full;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) alt_r <= in_altitude;
  end

  // Band pick: bases rise, so the last base at or below the altitude wins
  always_comb begin
    below = alt_r[ALT_W-1];
    idx   = '0;
    for (int i = 1; i < NB_USED; i++) begin
      if (alt_r[DIST_W-1:0] >= BASE_TAB[i][DIST_W-1:0]) idx = IDX_W'(i);
    end
    q_item.below = below;
    q_item.idx   = below ? '0 : idx;
    q_item.alt   = alt_r[DIST_W-1:0];
  end

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> hold_valid_r)
    else $error("accepted altitude not held");

endmodule

`default_nettype wire

>>> sv/ead_back.sv
// Evaluator: height above band base, rate multiply, base-2 exponential stages, rounding.
`default_nettype none

module ead_back import ead_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire item_t              q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [MANT_W-1:0]       out_density_mantissa,
  output logic signed [EXP_W-1:0] out_density_exponent,
  output logic [IDX_W-1:0]        out_band_index,
  output logic                    out_below_surface
);

  localparam int L = FRAC_BITS;

  logic en;

  // Band lookup stage
  logic              s1_valid_r;
  logic              s1_below_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic [K_W-1:0]    s1_rate_r;
  logic [MANT_W-1:0] s1_mant_r;
  logic [SEXP_W-1:0] s1_sexp_r;

  // Exponential stages: 0 holds the rate product, 1..L one fraction bit each
  logic              pv_r     [0:L];
  logic              pbelow_r [0:L];
  logic [IDX_W-1:0]  pidx_r   [0:L];
  logic [N_W-1:0]    pn_r     [0:L];
  logic [FRAC_BITS-1:0] pf_r  [0:L];
  logic [ACC_W-1:0]  pacc_r   [0:L];
  logic [SEXP_W-1:0] psexp_r  [0:L];

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_step [1:L];

  // Output register
  logic                    out_valid_r;
  logic [MANT_W-1:0]       out_mant_r,  out_mant_nxt;
  logic signed [EXP_W-1:0] out_exp_r,   out_exp_nxt;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_below_r;

  // Final normalize and round
  logic [ACC_W-1:0]  accf;
  logic [2:0]        sh;
  logic [ACC_W-1:0]  norm;
  logic [ACC_W:0]    rsum;
  logic [MANT_W:0]   m25;
  logic              carry;
  logic [MANT_W-1:0] mant_rnd;
  logic [DEC_W-1:0]  dec;
  logic              under;

  // Q30 by Q31 multiply, rounded back to Q30
  function automatic logic [ACC_W-1:0] mul_round(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] p);
    logic [2*ACC_W-1:0] full_w;
    full_w = ({{ACC_W{1'b0}}, a} * {{ACC_W{1'b0}}, p})
           + ({{(2*ACC_W-1){1'b0}}, 1'b1} << (ACC_W - 1));
    return full_w[2*ACC_W-1:ACC_W];
  endfunction

  // Whole pipeline moves when the output register can take a transfer
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_below_r <= q_item.below;
      s1_idx_r   <= q_item.idx;
      s1_dist_r  <= q_item.alt - BASE_TAB[q_item.idx][DIST_W-1:0];
      s1_rate_r  <= BAND_ROM[q_item.idx][63:37];
      s1_mant_r  <= {1'b1, BAND_ROM[q_item.idx][22:0]};
      s1_sexp_r  <= BAND_ROM[q_item.idx][28:23];
    end
  end

  // Height times rate: integer part of the result is a plain exponent drop
  assign prod = s1_dist_r * s1_rate_r;

  // One factor per fraction bit, MSB first
  always_comb begin
    for (int j = 1; j <= L; j++) begin
      acc_step[j] = pf_r[j-1][FRAC_BITS-j] ? mul_round(pacc_r[j-1], POW_TAB[j])
                                            : pacc_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= L; j++) pv_r[j] <= 1'b0;
    end else if (en) begin
      pv_r[0] <= s1_valid_r;
      for (int j = 1; j <= L; j++) pv_r[j] <= pv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pbelow_r[0] <= s1_below_r;
      pidx_r[0]   <= s1_idx_r;
      pn_r[0]     <= prod[PROD_W-1:44];
      pf_r[0]     <= prod[43:20];
      pacc_r[0]   <= {s1_mant_r, 7'b0};
      psexp_r[0]  <= s1_sexp_r;
      for (int j = 1; j <= L; j++) begin
        pbelow_r[j] <= pbelow_r[j-1];
        pidx_r[j]   <= pidx_r[j-1];
        pn_r[j]     <= pn_r[j-1];
        pf_r[j]     <= pf_r[j-1];
        pacc_r[j]   <= acc_step[j];
        psexp_r[j]  <= psexp_r[j-1];
      end
    end
  end

  // Renormalize (at most four shifts), round to 24 bits, build exponent
  always_comb begin
    accf = pacc_r[L];
    if (accf[ACC_W-1]) begin
      sh = 3'd0;
    end else if (accf[ACC_W-2]) begin
      sh = 3'd1;
    end else if (accf[ACC_W-3]) begin
      sh = 3'd2;
    end else if (accf[ACC_W-4]) begin
      sh = 3'd3;
    end else if (accf != '0) begin
      sh = 3'd4;
    end else begin
      sh = 3'd0;
    end
    norm     = ACC_W'(accf << sh);
    rsum     = {1'b0, norm} + (ACC_W+1)'(64);
    m25      = rsum[ACC_W:7];
    carry    = m25[MANT_W];
    mant_rnd = carry ? {1'b1, {(MANT_W-1){1'b0}}} : m25[MANT_W-1:0];
    dec      = DEC_W'(psexp_r[L]) + DEC_W'(sh) + DEC_W'(pn_r[L]);
    under    = (dec > (DEC_W'(255) + DEC_W'(carry))) || (mant_rnd == '0);
    if (pbelow_r[L] || under) begin
      out_mant_nxt = '0;
      out_exp_nxt  = '0;
    end else begin
      out_mant_nxt = mant_rnd;
      out_exp_nxt  = EXP_W'(carry) - EXP_W'(dec);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mant_r  <= out_mant_nxt;
      out_exp_r   <= out_exp_nxt;
      out_idx_r   <= pbelow_r[L] ? '0 : pidx_r[L];
      out_below_r <= pbelow_r[L];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_density_mantissa = out_mant_r;
  assign out_density_exponent = out_exp_r;
  assign out_band_index       = out_idx_r;
  assign out_below_surface    = out_below_r;

  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_below_r) |-> (out_mant_r[MANT_W-1] || (out_mant_r == '0)))
    else $error("density mantissa not normalized");

  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r <= IDX_W'(TABLE_LEN - 1)))
    else $error("band index beyond table");

endmodule

`default_nettype wire

>>> sv/exponential_atmosphere_density_top.sv
// Top level of the exponential atmosphere density block.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_altitude (Q16 km, signed)
//   out_     output     out_valid/out_stall  out_density_mantissa, out_density_exponent,
//                                            out_band_index, out_below_surface
//
// One altitude per cycle, sustained while out_stall is low; each altitude passes the holding
// register, queue, band lookup, rate multiply, 24 factor stages and output register in
// that order.
// The 24 factor stages, one multiplier each, make up most of the latency.
// Reset is synchronous and active low; the band table is constant and needs no sweep.
// out_stall freezes the evaluator; the front end keeps taking altitudes until
// the queue between them fills.
`default_nettype none

module exponential_atmosphere_density_top import ead_pkg::*; #(
  parameter int NUM_BANDS   = NUM_BANDS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ALT_W-1:0] in_altitude,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [MANT_W-1:0]            out_density_mantissa,
  output logic signed [EXP_W-1:0]      out_density_exponent,
  output logic [IDX_W-1:0]             out_band_index,
  output logic                         out_below_surface
);

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wr_item, q_rd_item;

  ead_front #(
    .NUM_BANDS(NUM_BANDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_altitude(in_altitude),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_wr_item)
  );

  ead_queue #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr_item),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_item),
    .empty  (q_empty)
  );

  ead_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (q_rd_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_density_mantissa(out_density_mantissa),
    .out_density_exponent(out_density_exponent),
    .out_band_index      (out_band_index),
    .out_below_surface   (out_below_surface)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the exponential atmosphere density block.
`timescale 1ns / 100ps

module testbench;
  import ead_pkg::*;

  localparam int CLK_HALF_NS = 4;
  localparam int TIMEOUT_NS  = 400_000;
  localparam int RANDOM_ITEMS = 315;
  localparam int FILL_ITEMS   = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // One result transfer
  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [EXP_W-1:0]  expo;
    logic [IDX_W-1:0]  band;
    logic              below;
  } density_t;

  // One directed stimulus row; the answer is typed in only where it is obvious
  typedef struct packed {
    logic signed [ALT_W-1:0] alt;
    logic                    typed;
    density_t                want;
  } stim_row_t;

  // Expected result with the altitude that caused it
  typedef struct packed {
    logic signed [ALT_W-1:0] alt;
    density_t                want;
  } pending_t;

  localparam density_t BELOW_SURFACE_RESULT = '{'0, '0, '0, 1'b1};
  // 1.225 kg/m^3 at sea level: 1.225 * 2^23 rounded
  localparam density_t SEA_LEVEL_RESULT     = '{24'h9CCCCD, '0, '0, 1'b0};
  localparam density_t NOT_TYPED            = '0;

  localparam int DIRECTED_ROWS = 21;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'sh8000_0000, 1'b1, BELOW_SURFACE_RESULT},
    '{-32'sd1,        1'b1, BELOW_SURFACE_RESULT},
    '{-32'sd65536,    1'b1, BELOW_SURFACE_RESULT},
    '{32'shAAAA_AAAA, 1'b1, BELOW_SURFACE_RESULT},
    '{32'sd0,         1'b1, SEA_LEVEL_RESULT},
    '{32'sd1,         1'b0, NOT_TYPED},
    '{32'sh0000_FFFF, 1'b0, NOT_TYPED},
    '{32'sh0018_FFFF, 1'b0, NOT_TYPED},
    '{32'sh0019_0000, 1'b0, NOT_TYPED},
    '{32'sh001E_0000, 1'b0, NOT_TYPED},
    '{32'sh0078_8000, 1'b0, NOT_TYPED},
    '{32'sh0096_0000, 1'b0, NOT_TYPED},
    '{32'sh00B3_FFFF, 1'b0, NOT_TYPED},
    '{32'sh01F4_0000, 1'b0, NOT_TYPED},
    '{32'sh03E7_FFFF, 1'b0, NOT_TYPED},
    '{32'sh03E8_0000, 1'b0, NOT_TYPED},
    '{32'sh03E8_0001, 1'b0, NOT_TYPED},
    '{32'sh7FFF_FFFF, 1'b0, NOT_TYPED},
    '{32'sh4000_0000, 1'b0, NOT_TYPED},
    '{32'sh5555_5555, 1'b0, NOT_TYPED},
    '{32'sh2AAA_AAAA, 1'b0, NOT_TYPED}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ALT_W-1:0]  in_altitude = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [MANT_W-1:0]        out_density_mantissa;
  logic signed [EXP_W-1:0]  out_density_exponent;
  logic [IDX_W-1:0]         out_band_index;
  logic                     out_below_surface;

  // Sideband travelling with the altitude being offered
  logic     cur_typed = 1'b0;
  density_t cur_want = '0;

  bit       hold_req = 1'b0;
  int       mismatches = 0;
  pending_t density_pending[$];

  // Band table and step factors of the predictor
  logic [MANT_W-1:0] band_mant    [TABLE_LEN];
  int unsigned       band_shift   [TABLE_LEN];
  int unsigned       band_base_km [TABLE_LEN];
  logic [K_W-1:0]    band_rate    [TABLE_LEN];
  logic [63:0]       root_half_pow[FRAC_BITS+1];

  exponential_atmosphere_density_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_altitude          (in_altitude),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_density_mantissa (out_density_mantissa),
    .out_density_exponent (out_density_exponent),
    .out_band_index       (out_band_index),
    .out_below_surface    (out_below_surface)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Band constants: normalized base density, binary shift, rate in Q28 per km
  initial begin : build_tables
    int          b;
    int          j;
    int          s;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] m;
    logic [63:0] rate;
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] cand;
    for (b = 0; b < TABLE_LEN; b++) begin
      num = 64'(RHO_DIGITS[b]);
      den = 64'd1;
      s   = 0;
      for (j = 0; j < int'(RHO_POW10[b]); j++) den = den * 64'd10;
      while (num < den) begin
        num = num << 1;
        s++;
      end
      while (num >= (den << 1)) begin
        den = den << 1;
        s--;
      end
      // long division for 23 fraction bits, then round to nearest
      m   = 64'd1;
      rem = num - den;
      for (j = 0; j < 23; j++) begin
        rem = rem << 1;
        m   = m << 1;
        if (rem >= den) begin
          rem = rem - den;
          m   = m | 64'd1;
        end
      end
      rem = rem << 1;
      if (rem >= den) m = m + 64'd1;
      if (m >= (64'd1 << 24)) begin
        m = m >> 1;
        s--;
      end
      band_mant[b]    = m[MANT_W-1:0];
      band_shift[b]   = s & 63;
      band_base_km[b] = BASE_KM[b];
      rate = (LOG2E_Q36 * 64'd1000 + 64'(SCALE_MILLI[b]) * 64'd128)
             / (64'(SCALE_MILLI[b]) * 64'd256);
      band_rate[b] = rate[K_W-1:0];
    end
    // 2^(-2^-i) in Q31: floor square root of the previous entry, bit by bit
    root_half_pow[0] = 64'd1 << 30;
    for (b = 1; b <= FRAC_BITS; b++) begin
      x = root_half_pow[b-1] << 31;
      r = '0;
      for (j = 31; j >= 0; j--) begin
        cand = r | (64'd1 << j);
        if (cand * cand <= x) r = cand;
      end
      root_half_pow[b] = r;
    end
  end

  // Density for one altitude: band lookup, base-2 exponential, renormalize, round
  function automatic density_t predict_density(input logic signed [ALT_W-1:0] alt);
    density_t              res;
    int                    band;
    int                    i;
    logic [63:0]           height;
    logic [63:0]           prod;
    logic [63:0]           acc;
    logic [63:0]           m24;
    logic [FRAC_BITS-1:0]  frac;
    longint                expo;
    res = '0;
    if (alt < 0) begin
      res.below = 1'b1;
      return res;
    end
    band = 0;
    for (i = 1; i < TABLE_LEN; i++) begin
      if (longint'(alt) >= longint'(band_base_km[i]) * 65536) band = i;
    end
    height = 64'(alt) - (64'(band_base_km[band]) << 16);
    prod   = height * 64'(band_rate[band]);
    frac = prod[43:20];
    acc  = 64'(band_mant[band]) << 7;
    expo = -longint'(band_shift[band]);
    for (i = 1; i <= FRAC_BITS; i++) begin
      if (frac[FRAC_BITS-i]) acc = (acc * root_half_pow[i] + (64'd1 << 30)) >> 31;
    end
    for (i = 0; i < 4; i++) begin
      if (acc != 0 && acc < (64'd1 << 30)) begin
        acc = acc << 1;
        expo--;
      end
    end
    m24 = (acc + 64'd64) >> 7;
    if (m24 >= (64'd1 << 24)) begin
      m24 = 64'd1 << 23;
      expo++;
    end
    expo = expo - longint'(prod >> 44);
    if (expo < -255 || m24 == 0) begin
      m24  = '0;
      expo = 0;
    end
    res.mant = m24[MANT_W-1:0];
    res.expo = expo[EXP_W-1:0];
    res.band = band[IDX_W-1:0];
    return res;
  endfunction

  // Random altitude: mostly inside the table, some at band edges, some anywhere, some below the surface
  function automatic logic signed [ALT_W-1:0] pick_altitude();
    int unsigned sel;
    int unsigned b;
    sel = $urandom_range(99, 0);
    b   = $urandom_range(TABLE_LEN - 1, 0);
    if (sel < 55) return ALT_W'(($urandom_range(1100, 0) << 16) | $urandom_range(65535, 0));
    if (sel < 75) return ALT_W'((int'(BASE_KM[b]) << 16) + int'($urandom_range(512, 0)) - 256);
    if (sel < 90) return ALT_W'($urandom);
    return ALT_W'($urandom | 32'h8000_0000);
  endfunction

  // Offer one altitude and wait for its transfer
  task automatic send_altitude(input logic signed [ALT_W-1:0] alt, input logic typed,
                               input density_t want);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_altitude <= alt;
    cur_typed   <= typed;
    cur_want    <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid    <= 1'b0;
      in_altitude <= $urandom;
    end
  endtask

  // Receiver: segments of free flow, random stall and a fixed stall pattern;
  // a long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    int unsigned phase;
    forever begin
      mode = $urandom_range(3, 0);
      len  = $urandom_range(60, 5);
      for (phase = 0; phase < len; phase++) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= 1'($urandom_range(1, 0));
            end
            2: begin
              out_stall <= (phase % 3 == 0);
            end
            default: begin
              out_stall <= ($urandom_range(3, 0) != 0);
            end
          endcase
        end
      end
    end
  end

  // Record expectations on input transfers, check result transfers
  always @(posedge clk) begin : scoreboard
    pending_t exp_item;
    density_t got;
    if (rst_n && in_valid && !in_stall) begin
      exp_item.alt  = in_altitude;
      exp_item.want = cur_typed ? cur_want : predict_density(in_altitude);
      density_pending.push_back(exp_item);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_density_mantissa, out_density_exponent, out_band_index, out_below_surface};
      if (density_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected: mant=%h exp=%0d band=%0d below=%b",
                   $realtime, got.mant, $signed(got.expo), got.band, got.below);
      end else begin
        exp_item = density_pending.pop_front();
        if (got !== exp_item.want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: alt=%h expected mant=%h exp=%0d band=%0d below=%b",
                     $realtime, exp_item.alt, exp_item.want.mant, $signed(exp_item.want.expo),
                     exp_item.want.band, exp_item.want.below);
            $display("%0t: alt=%h got      mant=%h exp=%0d band=%0d below=%b",
                     $realtime, exp_item.alt, got.mant, $signed(got.expo),
                     got.band, got.below);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int i;
    int sent;
    int burst;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows back to back
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_altitude(DIRECTED[i].alt, DIRECTED[i].typed, DIRECTED[i].want);
    idle_input(1);

    // sender pause until the pipeline is empty
    while (density_pending.size() != 0) @(posedge clk);

    // long receiver hold-off while the sender keeps offering: input must stall
    hold_req = 1'b1;
    for (i = 0; i < FILL_ITEMS; i++) send_altitude(pick_altitude(), 1'b0, NOT_TYPED);
    idle_input($urandom_range(4, 1));

    // random bursts and gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(40, 1);
      for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_altitude(pick_altitude(), 1'b0, NOT_TYPED);
        sent++;
      end
      idle_input($urandom_range(12, 0));
    end
    idle_input(1);

    while (density_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && density_pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
